[src/omec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package omec_pkg;
	localparam int FRAC_BITS = 4;
	localparam int SIZE_W = 14;
	localparam int COORD_W = 28;
	localparam int SPAN_W = SIZE_W + FRAC_BITS;   // 18
	localparam int OFS_W = COORD_W + 2;           // doubled offset, signed
	localparam int MAG_W = OFS_W - 1;
	localparam int PROD_W = MAG_W + SPAN_W;
	localparam int NUM_W = PROD_W + 2;
	localparam int DEN_W = MAG_W + 1;
	localparam int Q_W = SPAN_W;
	localparam int EDGE_W = 3;
	localparam logic [SIZE_W:0] VIEW_MAX = 15'd8192;
	localparam logic [SIZE_W-1:0] WIDTH_RST = 14'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [EDGE_W-1:0] EDGE_NONE = 3'd0;
	localparam logic [EDGE_W-1:0] EDGE_LEFT = 3'd1;
	localparam logic [EDGE_W-1:0] EDGE_RIGHT = 3'd2;
	localparam logic [EDGE_W-1:0] EDGE_TOP = 3'd3;
	localparam logic [EDGE_W-1:0] EDGE_BOTTOM = 3'd4;

	typedef struct packed {
		logic [Q_W-1:0] ox;
		logic [Q_W-1:0] oy;
		logic [EDGE_W-1:0] edge_hit;
		logic quot_x;
		logic quot_y;
	} side_t;
endpackage
`default_nettype wire

[src/offscreen_marker_edge_clamp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Off-screen marker edge clamp.
// Input stream (s_*): one point per transaction, screen_x/screen_y signed
// pixels*16 in s_tdata, on_screen flag in s_tuser. Output stream (m_*): one
// result per input, in order: out_x, out_y (pixels*16) and edge_hit.
// Points inside the viewport with on_screen set pass unchanged; a point at
// the exact center goes to the center; others move along the ray from the
// center onto the first edge it crosses. Stages: 6 front (offset, abs,
// cross products, edge select, placement products, numerator), 18 divider
// (one quotient bit each). One transaction per cycle when not stalled.
// A stalled output holds its result; the stall propagates back stage by
// stage, empty stages still fill, so s_tready drops only when the whole
// pipeline is full. Nothing is lost or repeated.
// Config: cfg_we writes cfg_data to view_width (index 0) or view_height
// (index 1); write only while the pipeline is empty. Zero acts as 1,
// values above 8192 act as 8192.
// Reset clears all valid bits and loads 1920 x 1080.
module offscreen_marker_edge_clamp_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [55:0] s_tdata,  // screen_x[27:0], screen_y[55:28]
	input  wire logic s_tuser,         // on_screen
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [39:0] m_tdata,       // out_x[17:0], out_y[35:18], edge_hit[38:36], 0
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [13:0] cfg_data
);
	localparam int SW = omec_pkg::SIZE_W;
	localparam int CW = omec_pkg::COORD_W;
	localparam int PW = omec_pkg::SPAN_W;
	localparam int OW = omec_pkg::OFS_W;
	localparam int MW = omec_pkg::MAG_W;
	localparam int XW = omec_pkg::PROD_W;
	localparam int NW = omec_pkg::NUM_W;
	localparam int DW = omec_pkg::DEN_W;
	localparam int QW = omec_pkg::Q_W;
	localparam int FB = omec_pkg::FRAC_BITS;

	logic [SW-1:0] width_q, height_q;
	logic [SW:0] w_sat, h_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= omec_pkg::WIDTH_RST;
			height_q <= omec_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				omec_pkg::REG_WIDTH: width_q <= cfg_data;
				omec_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_sat = {1'b0, width_q};
		h_sat = {1'b0, height_q};
		if (width_q == '0) w_sat = 15'd1;
		else if ({1'b0, width_q} > omec_pkg::VIEW_MAX) w_sat = omec_pkg::VIEW_MAX;
		if (height_q == '0) h_sat = 15'd1;
		else if ({1'b0, height_q} > omec_pkg::VIEW_MAX) h_sat = omec_pkg::VIEW_MAX;
	end

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6, div_ready;
	assign en6 = !v_s6 || div_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: doubled offsets from center, pass-through test
	logic signed [CW-1:0] in_x, in_y;
	logic signed [OW-1:0] x_e, y_e, wf_e, hf_e;
	logic [PW-1:0] wf, hf;
	logic pass;
	assign in_x = s_tdata[CW-1:0];
	assign in_y = s_tdata[2*CW-1:CW];
	assign wf = PW'({w_sat, {FB{1'b0}}});
	assign hf = PW'({h_sat, {FB{1'b0}}});
	assign x_e = OW'(in_x);
	assign y_e = OW'(in_y);
	assign wf_e = $signed({{(OW-PW){1'b0}}, wf});
	assign hf_e = $signed({{(OW-PW){1'b0}}, hf});
	assign pass = s_tuser && !in_x[CW-1] && !in_y[CW-1] && x_e <= wf_e && y_e <= hf_e;

	logic signed [OW-1:0] dx_s1, dy_s1;
	logic [PW-1:0] wf_s1, hf_s1, px_s1, py_s1;
	logic [SW:0] w_s1, h_s1;
	logic pass_s1;
	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1 <= (x_e <<< 1) - wf_e;
			dy_s1 <= (y_e <<< 1) - hf_e;
			wf_s1 <= wf; hf_s1 <= hf;
			w_s1 <= w_sat; h_s1 <= h_sat;
			px_s1 <= in_x[PW-1:0]; py_s1 <= in_y[PW-1:0];
			pass_s1 <= pass;
		end
	end

	// stage 2: magnitudes
	logic [MW-1:0] adx_s2, ady_s2;
	logic nx_s2, ny_s2, pass_s2;
	logic [PW-1:0] wf_s2, hf_s2, px_s2, py_s2;
	logic [SW:0] w_s2, h_s2;
	logic signed [OW-1:0] ndx, ndy;
	assign ndx = -dx_s1;
	assign ndy = -dy_s1;
	always_ff @(posedge clk) begin
		if (en2) begin
			adx_s2 <= dx_s1[OW-1] ? ndx[MW-1:0] : dx_s1[MW-1:0];
			ady_s2 <= dy_s1[OW-1] ? ndy[MW-1:0] : dy_s1[MW-1:0];
			nx_s2 <= dx_s1[OW-1]; ny_s2 <= dy_s1[OW-1];
			wf_s2 <= wf_s1; hf_s2 <= hf_s1; w_s2 <= w_s1; h_s2 <= h_s1;
			px_s2 <= px_s1; py_s2 <= py_s1; pass_s2 <= pass_s1;
		end
	end

	// stage 3: cross products for edge choice
	logic [MW+SW:0] cx_s3, cy_s3;
	logic [MW-1:0] adx_s3, ady_s3;
	logic nx_s3, ny_s3, pass_s3;
	logic [PW-1:0] wf_s3, hf_s3, px_s3, py_s3;
	always_ff @(posedge clk) begin
		if (en3) begin
			cx_s3 <= adx_s2 * h_s2;
			cy_s3 <= ady_s2 * w_s2;
			adx_s3 <= adx_s2; ady_s3 <= ady_s2;
			nx_s3 <= nx_s2; ny_s3 <= ny_s2;
			wf_s3 <= wf_s2; hf_s3 <= hf_s2;
			px_s3 <= px_s2; py_s3 <= py_s2; pass_s3 <= pass_s2;
		end
	end

	// stage 4: edge select; left/right wins a corner tie
	logic hit_lr, at_center;
	omec_pkg::side_t side4;
	assign hit_lr = cx_s3 >= cy_s3;
	assign at_center = adx_s3 == '0 && ady_s3 == '0;
	always_comb begin
		side4.ox = px_s3;
		side4.oy = py_s3;
		side4.edge_hit = omec_pkg::EDGE_NONE;
		side4.quot_x = 1'b0;
		side4.quot_y = 1'b0;
		if (pass_s3) begin
		end else if (at_center) begin
			side4.ox = wf_s3 >> 1;
			side4.oy = hf_s3 >> 1;
		end else if (hit_lr) begin
			side4.ox = nx_s3 ? '0 : wf_s3;
			side4.edge_hit = nx_s3 ? omec_pkg::EDGE_LEFT : omec_pkg::EDGE_RIGHT;
			side4.quot_y = 1'b1;
		end else begin
			side4.oy = ny_s3 ? '0 : hf_s3;
			side4.edge_hit = ny_s3 ? omec_pkg::EDGE_TOP : omec_pkg::EDGE_BOTTOM;
			side4.quot_x = 1'b1;
		end
	end

	logic [MW-1:0] lead_s4, mag_s4;
	logic [PW-1:0] span_s4, lspan_s4;
	logic neg_s4, divide_s4;
	omec_pkg::side_t side_s4;
	always_ff @(posedge clk) begin
		if (en4) begin
			lead_s4 <= hit_lr ? adx_s3 : ady_s3;
			mag_s4 <= hit_lr ? ady_s3 : adx_s3;
			span_s4 <= hit_lr ? hf_s3 : wf_s3;
			lspan_s4 <= hit_lr ? wf_s3 : hf_s3;
			neg_s4 <= hit_lr ? ny_s3 : nx_s3;
			divide_s4 <= !pass_s3 && !at_center;
			side_s4 <= side4;
		end
	end

	// stage 5: placement products
	logic [XW-1:0] base_s5, part_s5;
	logic [MW-1:0] lead_s5;
	logic neg_s5, divide_s5;
	omec_pkg::side_t side_s5;
	always_ff @(posedge clk) begin
		if (en5) begin
			base_s5 <= span_s4 * lead_s4;
			part_s5 <= mag_s4 * lspan_s4;
			lead_s5 <= lead_s4;
			neg_s5 <= neg_s4;
			divide_s5 <= divide_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: rounded numerator, divisor 2*lead (1 when no division)
	logic [NW-1:0] num_s6;
	logic [DW-1:0] den_s6;
	omec_pkg::side_t side_s6;
	logic [NW-1:0] base_e, part_e, lead_e;
	assign base_e = NW'(base_s5);
	assign part_e = NW'(part_s5);
	assign lead_e = NW'(lead_s5);
	always_ff @(posedge clk) begin
		if (en6) begin
			num_s6 <= divide_s5 ? (neg_s5 ? base_e - part_e : base_e + part_e) + lead_e : '0;
			den_s6 <= divide_s5 ? {lead_s5, 1'b0} : DW'(1);
			side_s6 <= side_s5;
		end
	end

	logic [QW-1:0] quot;
	omec_pkg::side_t side_o;
	omec_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s6),
		.in_ready(div_ready),
		.num(num_s6),
		.den(den_s6),
		.side_in(side_s6),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.quot(quot),
		.side_out(side_o)
	);

	logic [QW-1:0] out_x, out_y;
	assign out_x = side_o.quot_x ? quot : side_o.ox;
	assign out_y = side_o.quot_y ? quot : side_o.oy;
	assign m_tdata = {1'b0, side_o.edge_hit, out_y, out_x};

`ifndef SYNTHESIS
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready) else $error("input stalled with free output");
	a_left_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && side_o.edge_hit == omec_pkg::EDGE_LEFT |-> out_x == '0)
		else $error("left edge hit off x = 0");
	a_top_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && side_o.edge_hit == omec_pkg::EDGE_TOP |-> out_y == '0)
		else $error("top edge hit off y = 0");
	a_one_quot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(side_o.quot_x && side_o.quot_y))
		else $error("quotient routed to both axes");
`endif
endmodule
`default_nettype wire

[src/omec_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage, MSB first.
module omec_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [omec_pkg::NUM_W-1:0] num,
	input  wire logic [omec_pkg::DEN_W-1:0] den,
	input  wire omec_pkg::side_t side_in,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [omec_pkg::Q_W-1:0] quot,
	output omec_pkg::side_t side_out
);
	localparam int N = omec_pkg::Q_W;
	localparam int NW = omec_pkg::NUM_W;
	localparam int DW = omec_pkg::DEN_W;

	logic [N-1:0] v_q;
	logic [N:0] en;
	logic [NW-1:0] rem_q [N];
	logic [DW-1:0] den_q [N];
	logic [N-1:0] quot_q [N];
	omec_pkg::side_t side_q [N];

	assign en[N] = out_ready;
	assign in_ready = en[0];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [NW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [N-1:0] q_in;
		omec_pkg::side_t s_in;
		logic v_in;
		logic [NW-1:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign s_in = side_in;
			assign v_in = in_valid;
		end else begin : g_next
			assign r_in = rem_q[i-1];
			assign d_in = den_q[i-1];
			assign q_in = quot_q[i-1];
			assign s_in = side_q[i-1];
			assign v_in = v_q[i-1];
		end

		assign en[i] = !v_q[i] || en[i+1];
		assign trial = {{(NW-DW){1'b0}}, d_in} << (N - 1 - i);
		assign ge = r_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en[i]) begin
				v_q[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_q[i] <= ge ? r_in - trial : r_in;
				den_q[i] <= d_in;
				quot_q[i] <= q_in | ({{(N-1){1'b0}}, ge} << (N - 1 - i));
				side_q[i] <= s_in;
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign quot = quot_q[N-1];
	assign side_out = side_q[N-1];
endmodule
`default_nettype wire
